### hdl/ghash_pkg.sv
// Shared types, constants and helper functions for the GHASH block.
package ghash_pkg;

    localparam int unsigned BLOCK_W  = 128;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned COUNT_W  = 61;
    localparam int unsigned NBYTES_W = 5;
    localparam int unsigned BLOCK_BYTES = 16;

    localparam logic [7:0] RED_BYTE = 8'he1;

    typedef enum logic [1:0] {
        CMD_AAD    = 2'd0,
        CMD_TEXT   = 2'd1,
        CMD_FINISH = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic start;
    } t_mul_ctrl;

    typedef struct packed {
        logic done;
    } t_mul_status;

    // Keeps the leading n bytes of a block, n saturated at sixteen.
    function automatic logic [BLOCK_W-1:0] byte_mask(input logic [NBYTES_W-1:0] n);
        logic [BLOCK_W-1:0] m;
        m = '0;
        for (int b = 0; b < BLOCK_BYTES; b++) begin
            if (n > NBYTES_W'(b)) begin
                m[BLOCK_W-1-8*b -: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

### hdl/ghash_mult.sv
// Digit-serial GF(2^128) multiplier that consumes DIGIT_BITS bits of X per cycle.
module ghash_mult
    import ghash_pkg::*;
#(
    parameter int unsigned DIGIT_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_ctrl          i_ctrl,
    input  logic [BLOCK_W-1:0] i_x,
    input  logic [BLOCK_W-1:0] i_h,
    output t_mul_status        o_status,
    output logic [BLOCK_W-1:0] o_z
);

    localparam int unsigned NSTEP = (BLOCK_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int unsigned CNT_W = $clog2(NSTEP + 1);

    logic [BLOCK_W-1:0] r_x, n_x;
    logic [BLOCK_W-1:0] r_v, n_v;
    logic [BLOCK_W-1:0] r_z, n_z;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    always_comb begin
        logic [BLOCK_W-1:0] v;
        logic [BLOCK_W-1:0] z;
        logic               lsb;
        v = r_v;
        z = r_z;
        for (int d = 0; d < DIGIT_BITS; d++) begin
            if (r_x[BLOCK_W-1-d]) begin
                z = z ^ v;
            end
            lsb = v[0];
            v = v >> 1;
            if (lsb) begin
                v[BLOCK_W-1 -: 8] = v[BLOCK_W-1 -: 8] ^ RED_BYTE;
            end
        end
        n_v = v;
        n_z = z;
        n_x = r_x << DIGIT_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NSTEP);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_x <= i_x;
            r_v <= i_h;
            r_z <= '0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_v <= n_v;
            r_z <= n_z;
        end
    end

    assign o_status.done = r_done;
    assign o_z           = r_z;

endmodule

### hdl/ghash_gf128_hash.sv
// GHASH over GF(2^128) for GCM: accumulator, byte counts, sequencer and output register.
//
// Each AAD or text word with a nonzero byte count is zero-padded, folded into the
// accumulator and multiplied by the hash key H in a shared digit-serial multiplier
// that consumes DIGIT_BITS bits of the accumulator per cycle, and the block takes no new
// word until the multiply is done. A finish word folds in the 64-bit AAD and text bit
// lengths, runs the same multiply, places the hash in the output register and clears
// the accumulator and both counts. Words with a byte count of zero and unknown
// commands are accepted and do nothing. The output register lets a new word start
// while a digest waits to be taken. The user must write the key through the
// configuration port only while the block is idle; the block does not enforce it.
module ghash_gf128_hash
    import ghash_pkg::*;
#(
    parameter int unsigned DIGIT_BITS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [WORD_W-1:0]   i_cfg_data,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_command,
    input  logic [WORD_W-1:0]   i_block_high,
    input  logic [WORD_W-1:0]   i_block_low,
    input  logic [NBYTES_W-1:0] i_byte_count,

    output logic                o_valid,
    input  logic                i_ready,
    output logic [WORD_W-1:0]   o_digest_high,
    output logic [WORD_W-1:0]   o_digest_low
);

    t_state              r_state, n_state;
    logic [BLOCK_W-1:0]  r_acc;
    logic [COUNT_W-1:0]  r_aad_bytes;
    logic [COUNT_W-1:0]  r_text_bytes;
    logic [WORD_W-1:0]   r_key_high;
    logic [WORD_W-1:0]   r_key_low;
    logic                r_finish;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_digest_high;
    logic [WORD_W-1:0]   r_digest_low;

    logic                accept;
    logic [NBYTES_W-1:0] nbytes;
    logic                data_word;
    logic                finish_word;
    logic [BLOCK_W-1:0]  mul_x;
    logic                out_free;
    logic                emit;
    t_mul_ctrl           mul_ctrl;
    t_mul_status         mul_status;
    logic [BLOCK_W-1:0]  mul_z;

    assign accept   = i_valid && o_ready;
    assign nbytes   = (i_byte_count > NBYTES_W'(BLOCK_BYTES)) ? NBYTES_W'(BLOCK_BYTES)
                                                             : i_byte_count;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        data_word   = 1'b0;
        finish_word = 1'b0;
        mul_x       = r_acc;
        case (t_cmd'(i_command))
            CMD_AAD, CMD_TEXT: begin
                data_word = (nbytes != '0);
                mul_x     = r_acc ^ ({i_block_high, i_block_low} & byte_mask(nbytes));
            end
            CMD_FINISH: begin
                finish_word = 1'b1;
                mul_x       = r_acc ^ {r_aad_bytes, 3'b000, r_text_bytes, 3'b000};
            end
            default: begin
                data_word   = 1'b0;
                finish_word = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (data_word || finish_word)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_status.done) begin
                    n_state = r_finish ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        mul_ctrl.start = 1'b0;
        emit           = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready        = 1'b1;
                mul_ctrl.start = i_valid && (data_word || finish_word);
            end
            ST_MUL: begin
                o_ready = 1'b0;
            end
            ST_EMIT: begin
                emit = out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    ghash_mult #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mul_ctrl),
        .i_x      (mul_x),
        .i_h      ({r_key_high, r_key_low}),
        .o_status (mul_status),
        .o_z      (mul_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_acc        <= '0;
            r_aad_bytes  <= '0;
            r_text_bytes <= '0;
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_finish     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    default: begin
                        r_key_high <= r_key_high;
                    end
                endcase
            end

            if (accept && (data_word || finish_word)) begin
                r_finish <= finish_word;
                if (finish_word) begin
                    r_aad_bytes  <= '0;
                    r_text_bytes <= '0;
                end else if (t_cmd'(i_command) == CMD_AAD) begin
                    r_aad_bytes <= r_aad_bytes + COUNT_W'(nbytes);
                end else begin
                    r_text_bytes <= r_text_bytes + COUNT_W'(nbytes);
                end
            end

            if (r_state == ST_MUL && mul_status.done) begin
                r_acc <= mul_z;
            end else if (emit) begin
                r_acc <= '0;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_digest_high <= r_acc[BLOCK_W-1 -: WORD_W];
            r_digest_low  <= r_acc[WORD_W-1:0];
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_digest_high = r_digest_high;
    assign o_digest_low  = r_digest_low;

endmodule
